/* design/assert_macros.svh */
// Assertion macros used by the top level of the ack-frequency receiver policy RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Plain property, checked at every rising edge outside reset.
`define ACKF_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Same-cycle implication.
`define ACKF_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define ACKF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ACKF_ASSERT(lbl, clk, rst_n, prop, msg)
`define ACKF_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define ACKF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* design/ackf_pkg.sv */
// Types, codes and constants of the ack-frequency receiver policy.
`default_nettype none
package ackf_pkg;

	localparam int VAL_W   = 62;
	localparam int COUNT_W = 32;
	localparam int USED_W  = 6;
	localparam int CFG_W   = 8;

	// command codes
	localparam logic [1:0] CMD_FRAME_BYTE = 2'd0;
	localparam logic [1:0] CMD_IMMEDIATE  = 2'd1;
	localparam logic [1:0] CMD_QUERY      = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_APPLIED   = 2'd0;
	localparam logic [1:0] KIND_STALE     = 2'd1;
	localparam logic [1:0] KIND_TRUNCATED = 2'd2;
	localparam logic [1:0] KIND_DECISION  = 2'd3;

	// packet number spaces
	localparam logic [1:0] SPACE_INITIAL   = 2'd0;
	localparam logic [1:0] SPACE_HANDSHAKE = 2'd1;
	localparam logic [1:0] SPACE_APP       = 2'd2;

	// configuration register indexes
	localparam logic REG_FALLBACK_THRESHOLD = 1'b0;
	localparam logic REG_FALLBACK_REORDER   = 1'b1;

	// frame layout: sequence, threshold, max delay, reorder threshold
	localparam logic [1:0] FIELD_LAST = 2'd3;

	localparam logic [VAL_W-1:0] RST_THRESHOLD = 62'd2;
	localparam logic [VAL_W-1:0] RST_DELAY     = 62'd25000;
	localparam logic [VAL_W-1:0] RST_REORDER   = 62'd1;
	localparam logic [CFG_W-1:0] RST_FALLBACK_THRESHOLD = 8'd2;
	localparam logic [CFG_W-1:0] RST_FALLBACK_REORDER   = 8'd1;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [7:0]         data_byte;
		logic               last_byte;
		logic [1:0]         pkt_space;
		logic [COUNT_W-1:0] eliciting_count;
		logic [VAL_W-1:0]   largest_received;
		logic [VAL_W-1:0]   largest_acked_before;
	} in_item_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic              send_ack;
		logic [USED_W-1:0] bytes_used;
		logic [VAL_W-1:0]  delay_limit_us;
	} out_item_t;

	// stored ack-frequency parameters
	typedef struct packed {
		logic [VAL_W-1:0] sequence_num;
		logic [VAL_W-1:0] threshold;
		logic [VAL_W-1:0] delay;
		logic [VAL_W-1:0] reorder;
	} params_t;

	// frame parser outcome for the byte in stage 1
	typedef struct packed {
		logic              valid;
		logic [1:0]        kind;
		logic [USED_W-1:0] bytes_used;
	} frame_res_t;

endpackage
`default_nettype wire

/* design/ackf_in_if.sv */
// Input channel: valid/ready handshake carrying one policy command.
`default_nettype none
interface ackf_in_if;
	logic              valid;
	logic              ready;
	ackf_pkg::in_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

/* design/ackf_out_if.sv */
// Output channel: valid/ready handshake carrying one policy result.
`default_nettype none
interface ackf_out_if;
	logic               valid;
	logic               ready;
	ackf_pkg::out_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

/* design/ackf_frame_parser.sv */
// Varint frame parser and stored ack-frequency parameters.
`default_nettype none
module ackf_frame_parser (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 fire,
	input  wire logic [7:0]           data_byte,
	input  wire logic                 last_byte,
	output ackf_pkg::frame_res_t      res,
	output ackf_pkg::params_t         params
);
	import ackf_pkg::*;

	logic [1:0]        field_idx_q, field_idx_n;
	logic [2:0]        left_q, left_n;
	logic [VAL_W-1:0]  acc_q, acc_n;
	logic [USED_W-1:0] byte_cnt_q, byte_cnt_n;
	logic              discard_q, discard_n;
	params_t           params_q, params_n;
	logic [VAL_W-1:0]  captured_q [3];
	logic [VAL_W-1:0]  field_val;
	logic              cap_we;
	logic              stale;

	always_comb begin
		field_idx_n = field_idx_q;
		left_n      = left_q;
		acc_n       = acc_q;
		byte_cnt_n  = byte_cnt_q;
		discard_n   = discard_q;
		params_n    = params_q;
		field_val   = '0;
		cap_we      = 1'b0;
		stale       = 1'b0;
		res         = '0;
		if (discard_q) begin
			// drop the tail of a run after a completed frame
			if (last_byte) begin
				discard_n = 1'b0;
			end
		end else begin
			byte_cnt_n = byte_cnt_q + 6'd1;
			if (left_q == 3'd0) begin
				left_n = 3'((4'd1 << data_byte[7:6]) - 4'd1);
				acc_n  = {56'd0, data_byte[5:0]};
			end else begin
				left_n = left_q - 3'd1;
				acc_n  = {acc_q[VAL_W-9:0], data_byte};
			end
			field_val = acc_n;
			if (left_n == 3'd0 && field_idx_q != FIELD_LAST) begin
				cap_we      = 1'b1;
				field_idx_n = field_idx_q + 2'd1;
				acc_n       = '0;
			end else if (left_n == 3'd0) begin
				stale = (captured_q[0] <= params_q.sequence_num) &&
					(params_q.sequence_num != '0);
				if (!stale) begin
					params_n.sequence_num = captured_q[0];
					params_n.threshold    = captured_q[1];
					params_n.delay        = captured_q[2];
					params_n.reorder      = acc_n;
				end
				res.valid      = 1'b1;
				res.kind       = stale ? KIND_STALE : KIND_APPLIED;
				res.bytes_used = byte_cnt_n;
				discard_n      = !last_byte;
			end
			if (last_byte && !res.valid) begin
				res.valid = 1'b1;
				res.kind  = KIND_TRUNCATED;
			end
			if (res.valid) begin
				field_idx_n = '0;
				left_n      = '0;
				acc_n       = '0;
				byte_cnt_n  = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_idx_q <= '0;
			left_q      <= '0;
			acc_q       <= '0;
			byte_cnt_q  <= '0;
			discard_q   <= 1'b0;
			params_q    <= '{sequence_num: '0, threshold: RST_THRESHOLD,
				delay: RST_DELAY, reorder: RST_REORDER};
		end else if (fire) begin
			field_idx_q <= field_idx_n;
			left_q      <= left_n;
			acc_q       <= acc_n;
			byte_cnt_q  <= byte_cnt_n;
			discard_q   <= discard_n;
			params_q    <= params_n;
		end
	end

	// fields are written before the final field reads them
	always_ff @(posedge clk) begin
		if (fire && cap_we) begin
			captured_q[field_idx_q] <= field_val;
		end
	end

	assign params = params_q;

endmodule
`default_nettype wire

/* design/ackf_ack_decider.sv */
// Ack decision rules, immediate-ack flag and fallback registers.
`default_nettype none
module ackf_ack_decider (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_index,
	input  wire logic [ackf_pkg::CFG_W-1:0]    cfg_wdata,
	input  wire logic                          fire_immediate,
	input  wire logic                          fire_query,
	input  wire logic [1:0]                    pkt_space,
	input  wire logic [ackf_pkg::COUNT_W-1:0]  eliciting_count,
	input  wire logic [ackf_pkg::VAL_W-1:0]    largest_received,
	input  wire logic [ackf_pkg::VAL_W-1:0]    largest_acked_before,
	input  wire ackf_pkg::params_t             params,
	output logic                               send_ack
);
	import ackf_pkg::*;

	logic [CFG_W-1:0] fb_threshold_q;
	logic [CFG_W-1:0] fb_reorder_q;
	logic             pending_q;
	logic [VAL_W-1:0] thr;
	logic [VAL_W-1:0] reo;
	logic [VAL_W:0]   gap_limit;
	logic             gap_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_threshold_q <= RST_FALLBACK_THRESHOLD;
			fb_reorder_q   <= RST_FALLBACK_REORDER;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FALLBACK_THRESHOLD: fb_threshold_q <= cfg_wdata;
				REG_FALLBACK_REORDER:   fb_reorder_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		thr       = (params.threshold != '0) ? params.threshold : {54'd0, fb_threshold_q};
		reo       = (params.reorder != '0) ? params.reorder : {54'd0, fb_reorder_q};
		gap_limit = {1'b0, largest_acked_before} + {1'b0, reo};
		gap_hit   = (reo != '0) && (largest_acked_before != '0) &&
			({1'b0, largest_received} > gap_limit);
		case (pkt_space)
			SPACE_INITIAL, SPACE_HANDSHAKE: send_ack = (eliciting_count != '0);
			SPACE_APP: send_ack = pending_q || ({30'd0, eliciting_count} > thr) || gap_hit;
			default: send_ack = 1'b0;
		endcase
	end

	// set on an immediate-ack event, consume on the first application query
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
		end else if (fire_immediate) begin
			pending_q <= 1'b1;
		end else if (fire_query && pkt_space == SPACE_APP) begin
			pending_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

/* design/ack_frequency_receiver_policy_unit.sv */
// Top level of the ack-frequency receiver policy: stage registers and handshakes.
//
//  channel   dir  handshake          transaction
//  item      in   valid/ready        one command: frame byte, immediate-ack, query
//  result    out  valid/ready        applied / stale / truncated / decision
//  cfg_*     in   write enable only  fallback threshold or fallback reorder
//
// One item per cycle unless stage 2 stalls; a result is registered in stage 2.
// Stage 1 registers the item, the parser and decider act on it and stage 2 holds the result.
// Items with no result pass through stage 1 even while a result waits in stage 2.
// Reset clears parser state, pending flag and both stage valids; parameters get defaults.
`default_nettype none
`include "assert_macros.svh"
module ack_frequency_receiver_policy_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	ackf_in_if.sink                         item,
	ackf_out_if.source                      result,
	input  wire logic                       cfg_we,
	input  wire logic                       cfg_index,
	input  wire logic [ackf_pkg::CFG_W-1:0] cfg_wdata
);
	import ackf_pkg::*;

	logic       valid_s1;
	in_item_t   item_s1;
	logic       valid_s2;
	out_item_t  res_s2;
	logic       advance;
	logic       has_res;
	out_item_t  res;
	frame_res_t frame_res;
	params_t    params;
	logic       send_ack;
	logic       is_byte;
	logic       is_query;

	assign is_byte  = (item_s1.cmd == CMD_FRAME_BYTE);
	assign is_query = (item_s1.cmd == CMD_QUERY);

	ackf_frame_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (advance && is_byte),
		.data_byte (item_s1.data_byte),
		.last_byte (item_s1.last_byte),
		.res       (frame_res),
		.params    (params)
	);

	ackf_ack_decider u_decider (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg_we               (cfg_we),
		.cfg_index            (cfg_index),
		.cfg_wdata            (cfg_wdata),
		.fire_immediate       (advance && item_s1.cmd == CMD_IMMEDIATE),
		.fire_query           (advance && is_query),
		.pkt_space            (item_s1.pkt_space),
		.eliciting_count      (item_s1.eliciting_count),
		.largest_received     (item_s1.largest_received),
		.largest_acked_before (item_s1.largest_acked_before),
		.params               (params),
		.send_ack             (send_ack)
	);

	always_comb begin
		res = '0;
		if (is_query) begin
			res.kind           = KIND_DECISION;
			res.send_ack       = send_ack;
			res.delay_limit_us = params.delay;
		end else begin
			res.kind       = frame_res.kind;
			res.bytes_used = frame_res.bytes_used;
		end
	end

	assign has_res    = is_query || (is_byte && frame_res.valid);
	// hold stage 1 only when its result cannot enter stage 2
	assign advance    = valid_s1 && (!has_res || !valid_s2 || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && has_res) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_res) begin
			res_s2 <= res;
		end
	end

	assign result.valid = valid_s2;
	assign result.data  = res_s2;

	`ACKF_ASSERT_IMPLY(a_no_overwrite, clk, arst_n, valid_s2 && !result.ready && has_res, !advance, "result overwritten while stalled")
	`ACKF_ASSERT_NEXT(a_result_loaded, clk, arst_n, advance && has_res, valid_s2, "result lost after advance")
	`ACKF_ASSERT_IMPLY(a_decision_fields, clk, arst_n, valid_s2 && res_s2.kind == KIND_DECISION, res_s2.bytes_used == '0, "decision carries byte count")
	`ACKF_ASSERT_IMPLY(a_frame_fields, clk, arst_n, valid_s2 && res_s2.kind != KIND_DECISION, !res_s2.send_ack && res_s2.delay_limit_us == '0, "frame result carries decision fields")
	`ACKF_ASSERT_IMPLY(a_frame_used, clk, arst_n, valid_s2 && (res_s2.kind == KIND_APPLIED || res_s2.kind == KIND_STALE), res_s2.bytes_used != '0, "completed frame with no bytes")

endmodule
`default_nettype wire

/* tb/ack_frequency_receiver_policy_unit_test.sv */
// Self-checking testbench of the ack-frequency receiver policy unit with a predicting scoreboard.
`default_nettype none
module ack_frequency_receiver_policy_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import ackf_pkg::*;

	localparam logic [1:0] CMD_UNDEFINED = 2'd3;
	localparam logic [1:0] SPACE_INVALID = 2'd3;
	localparam logic [VAL_W-1:0] VAL_MAX = '1;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 4;

	// Tracks the parser, stored parameters and pending flag; queues the results they imply.
	class ack_result_predictor;
		logic [CFG_W-1:0]  fallback_thr;
		logic [CFG_W-1:0]  fallback_reo;
		logic [1:0]        field_idx;
		logic [2:0]        bytes_left;
		logic [VAL_W-1:0]  accum;
		logic [USED_W-1:0] byte_cnt;
		bit                dropping;
		logic [VAL_W-1:0]  captured[3];
		params_t           stored;
		bit                immediate;
		out_item_t         pending_results[$];
		int                mismatches;

		function new();
			fallback_thr = RST_FALLBACK_THRESHOLD;
			fallback_reo = RST_FALLBACK_REORDER;
			restart();
			dropping = 1'b0;
			foreach (captured[i]) captured[i] = '0;
			stored = {{VAL_W{1'b0}}, RST_THRESHOLD, RST_DELAY, RST_REORDER};
			immediate = 1'b0;
			mismatches = 0;
		endfunction

		function void restart();
			field_idx = '0;
			bytes_left = '0;
			accum = '0;
			byte_cnt = '0;
		endfunction

		function void take_byte(logic [7:0] b, logic last);
			out_item_t r;
			bit done;
			r = '0;
			// drop the remainder of a run whose frame already completed
			if (dropping) begin
				if (last) dropping = 1'b0;
				return;
			end
			byte_cnt++;
			if (bytes_left == 0) begin
				accum = {{(VAL_W-6){1'b0}}, b[5:0]};
				bytes_left = 3'((1 << b[7:6]) - 1);
			end else begin
				accum = {accum[VAL_W-9:0], b};
				bytes_left--;
			end
			done = (bytes_left == 0);
			if (done && field_idx != FIELD_LAST) begin
				captured[field_idx] = accum;
				field_idx++;
				accum = '0;
				done = 1'b0;
			end else if (done) begin
				r.bytes_used = byte_cnt;
				if (captured[0] <= stored.sequence_num && stored.sequence_num != 0) begin
					r.kind = KIND_STALE;
				end else begin
					stored = {captured[0], captured[1], captured[2], accum};
					r.kind = KIND_APPLIED;
				end
				restart();
				dropping = !last;
				pending_results.push_back(r);
				return;
			end
			if (last) begin
				restart();
				r.kind = KIND_TRUNCATED;
				pending_results.push_back(r);
			end
		endfunction

		function bit ack_now(in_item_t it);
			logic [VAL_W-1:0] thr;
			logic [VAL_W-1:0] reo;
			logic [63:0]      reach;
			if (it.pkt_space == SPACE_INVALID) return 1'b0;
			if (it.pkt_space != SPACE_APP) return it.eliciting_count != 0;
			if (immediate) begin
				immediate = 1'b0;
				return 1'b1;
			end
			thr = (stored.threshold != 0) ? stored.threshold : VAL_W'(fallback_thr);
			if (VAL_W'(it.eliciting_count) > thr) return 1'b1;
			reo = (stored.reorder != 0) ? stored.reorder : VAL_W'(fallback_reo);
			reach = 64'(it.largest_acked_before) + 64'(reo);
			return reo != 0 && it.largest_acked_before != 0 && 64'(it.largest_received) > reach;
		endfunction

		function void note_item(in_item_t it);
			out_item_t r;
			r = '0;
			case (it.cmd)
				CMD_FRAME_BYTE: take_byte(it.data_byte, it.last_byte);
				CMD_IMMEDIATE: immediate = 1'b1;
				CMD_QUERY: begin
					r.kind = KIND_DECISION;
					r.send_ack = ack_now(it);
					r.delay_limit_us = stored.delay;
					pending_results.push_back(r);
				end
				default: ;
			endcase
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (pending_results.size() == 0) begin
				$error("unexpected result: kind %0d send_ack %0d bytes_used %0d delay %0d",
					got.kind, got.send_ack, got.bytes_used, got.delay_limit_us);
				mismatches++;
				return;
			end
			want = pending_results.pop_front();
			if (got.kind !== want.kind) begin
				$error("kind: expected %0d, got %0d", want.kind, got.kind);
				mismatches++;
			end
			if (got.send_ack !== want.send_ack) begin
				$error("send_ack: expected %0d, got %0d", want.send_ack, got.send_ack);
				mismatches++;
			end
			if (got.bytes_used !== want.bytes_used) begin
				$error("bytes_used: expected %0d, got %0d", want.bytes_used, got.bytes_used);
				mismatches++;
			end
			if (got.delay_limit_us !== want.delay_limit_us) begin
				$error("delay_limit_us: expected %0d, got %0d",
					want.delay_limit_us, got.delay_limit_us);
				mismatches++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic             cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	ackf_in_if  item_ch();
	ackf_out_if result_ch();

	ack_result_predictor policy = new();

	int src_idle_pct = 19;
	int snk_idle_pct = 70;
	int hold_requests = 0;
	int item_total = 0;
	logic [7:0] frame_bytes[$];

	ack_frequency_receiver_policy_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#3_200_000;
		$display("ack_frequency_receiver_policy_unit regression: fail");
		$finish;
	end

	// result side: check each transaction, then pick ready for the next cycle
	initial begin
		int seen;
		int hold_left;
		seen = 0;
		hold_left = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_ch.valid && result_ch.ready)
				policy.check_result(result_ch.data);
			if (hold_requests != seen) begin
				seen = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	function automatic logic [VAL_W-1:0] rand_val();
		return VAL_W'({$urandom, $urandom});
	endfunction

	function automatic in_item_t rand_item(input logic [1:0] cmd);
		in_item_t it;
		it.cmd = cmd;
		it.data_byte = 8'($urandom);
		it.last_byte = 1'($urandom);
		it.pkt_space = 2'($urandom);
		it.eliciting_count = $urandom;
		it.largest_received = rand_val();
		it.largest_acked_before = rand_val();
		return it;
	endfunction

	function automatic in_item_t make_query(input logic [1:0] space,
		input logic [COUNT_W-1:0] count, input logic [VAL_W-1:0] largest,
		input logic [VAL_W-1:0] acked);
		in_item_t it;
		it = rand_item(CMD_QUERY);
		it.pkt_space = space;
		it.eliciting_count = count;
		it.largest_received = largest;
		it.largest_acked_before = acked;
		return it;
	endfunction

	function automatic in_item_t rand_query();
		in_item_t it;
		int pick;
		it = rand_item(CMD_QUERY);
		if ($urandom_range(99) < 60) it.pkt_space = SPACE_APP;
		pick = $urandom_range(99);
		if (pick < 40) it.eliciting_count = $urandom_range(0, 6);
		else if (pick < 70) it.eliciting_count = $urandom_range(0, 300);
		pick = $urandom_range(99);
		if (pick < 15) it.largest_acked_before = '0;
		else if (pick < 65) it.largest_acked_before = VAL_W'($urandom_range(1, 1000));
		// keep the reorder gap near the threshold most of the time
		if ($urandom_range(99) < 60)
			it.largest_received = it.largest_acked_before + VAL_W'($urandom_range(0, 300));
		return it;
	endfunction

	function automatic in_item_t random_event();
		int pick;
		pick = $urandom_range(99);
		if (pick < 40) return rand_item(CMD_IMMEDIATE);
		if (pick < 95) return rand_query();
		return rand_item(CMD_UNDEFINED);
	endfunction

	// len_code < 0 picks a random encoding length that fits the value
	function automatic void add_varint(input logic [VAL_W-1:0] v, input int len_code);
		int code;
		int len;
		logic [63:0] w;
		code = (v < 64) ? 0 : (v < (1 << 14)) ? 1 : (v < (1 << 30)) ? 2 : 3;
		if (len_code < 0) code = $urandom_range(3, code);
		else if (len_code > code) code = len_code;
		len = 1 << code;
		w = 64'(v) | (64'(code) << (len * 8 - 2));
		for (int i = len - 1; i >= 0; i--) frame_bytes.push_back(w[i*8 +: 8]);
	endfunction

	function automatic logic [VAL_W-1:0] next_sequence();
		logic [VAL_W-1:0] cur;
		cur = policy.stored.sequence_num;
		if (cur != 0 && $urandom_range(99) < 12)
			return (cur > 3) ? cur - VAL_W'($urandom_range(0, 3)) : cur;
		return cur + VAL_W'($urandom_range(1, 40));
	endfunction

	function automatic logic [VAL_W-1:0] rand_param(input int zero_pct, input int small_max);
		int pick;
		pick = $urandom_range(99);
		if (pick < zero_pct) return '0;
		if (pick < 80) return VAL_W'($urandom_range(1, small_max));
		return rand_val();
	endfunction

	task automatic put_item(input in_item_t it);
		while ($urandom_range(99) < src_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data <= it;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		policy.note_item(it);
		if (it.cmd != CMD_UNDEFINED) item_total++;
	endtask

	// 0 < cut < frame length ends the run early; otherwise tail > 0 appends bytes that the parser drops
	task automatic send_frame(input logic [VAL_W-1:0] sq, input logic [VAL_W-1:0] th,
		input logic [VAL_W-1:0] dl, input logic [VAL_W-1:0] ro, input int len_code,
		input int cut, input int tail, input int mix_pct);
		in_item_t it;
		int n;
		frame_bytes.delete();
		add_varint(sq, len_code);
		add_varint(th, len_code);
		add_varint(dl, len_code);
		add_varint(ro, len_code);
		n = frame_bytes.size();
		if (cut > 0 && cut < n) begin
			n = cut;
		end else if (tail > 0) begin
			repeat (tail) frame_bytes.push_back(8'($urandom));
			n = frame_bytes.size();
		end
		for (int i = 0; i < n; i++) begin
			if (i > 0 && $urandom_range(99) < mix_pct) put_item(random_event());
			it = rand_item(CMD_FRAME_BYTE);
			it.data_byte = frame_bytes[i];
			it.last_byte = (i == n - 1);
			put_item(it);
		end
	endtask

	task automatic random_frame();
		int cut;
		int tail;
		int mix;
		cut = ($urandom_range(99) < 10) ? $urandom_range(1, 7) : 0;
		tail = ($urandom_range(99) < 10) ? $urandom_range(1, 3) : 0;
		mix = ($urandom_range(99) < 30) ? 20 : 0;
		send_frame(next_sequence(), rand_param(30, 10), rand_param(10, 60000),
			rand_param(30, 12), -1, cut, tail, mix);
	endtask

	task automatic run_random(input int goal);
		int start;
		int pick;
		int n;
		in_item_t it;
		start = item_total;
		while (item_total - start < goal) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				random_frame();
			end else if (pick < 90) begin
				put_item(random_event());
			end else begin
				// short broken run: always too short to finish a frame
				n = $urandom_range(1, 3);
				for (int i = 0; i < n; i++) begin
					it = rand_item(CMD_FRAME_BYTE);
					it.last_byte = (i == n - 1);
					put_item(it);
				end
			end
		end
	endtask

	task automatic drain(input int extra);
		item_ch.valid <= 1'b0;
		while (policy.pending_results.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_regs(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] reo);
		cfg_we <= 1'b1;
		cfg_index <= REG_FALLBACK_THRESHOLD;
		cfg_wdata <= thr;
		@(posedge clk);
		cfg_index <= REG_FALLBACK_REORDER;
		cfg_wdata <= reo;
		@(posedge clk);
		cfg_we <= 1'b0;
		policy.fallback_thr = thr;
		policy.fallback_reo = reo;
	endtask

	task automatic directed();
		put_item(make_query(SPACE_INITIAL, '0, '0, '0));
		put_item(make_query(SPACE_HANDSHAKE, '1, VAL_MAX, VAL_MAX));
		put_item(make_query(SPACE_INVALID, '1, VAL_MAX, 62'd1));
		put_item(make_query(SPACE_APP, '0, '0, '0));
		put_item(make_query(SPACE_APP, 32'd3, '0, '0));
		put_item(rand_item(CMD_IMMEDIATE));
		put_item(make_query(SPACE_INITIAL, '0, '0, '0));
		put_item(make_query(SPACE_APP, '0, '0, '0));
		put_item(make_query(SPACE_APP, '0, '0, '0));
		put_item(rand_item(CMD_UNDEFINED));
		// zero threshold and reorder: decisions fall back to the registers
		send_frame(62'd5, '0, VAL_MAX, '0, -1, 0, 0, 0);
		put_item(make_query(SPACE_APP, 32'd2, 62'd10, 62'd9));
		put_item(make_query(SPACE_APP, 32'd2, 62'd11, 62'd9));
		put_item(make_query(SPACE_APP, '0, VAL_MAX, VAL_MAX - 62'd1));
		send_frame(62'd5, 62'd1, 62'd100, 62'd1, 3, 0, 0, 0);
		send_frame(62'd9, 62'd3, 62'd200, 62'd2, -1, 2, 0, 0);
		send_frame(62'd7, 62'd3, 62'd200, 62'd2, -1, 0, 2, 0);
		send_frame(62'd8, '0, 62'd63, '0, 0, 0, 0, 60);
	endtask

	initial begin
		arst_n <= 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.data <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_FALLBACK_THRESHOLD;
		cfg_wdata <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed();
		drain(SETTLE_CYCLES);
		write_regs(8'd1, 8'd0);
		run_random(180);

		drain(SETTLE_CYCLES);
		write_regs(8'd255, 8'd255);
		src_idle_pct = 70;
		snk_idle_pct = 19;
		run_random(180);

		drain(SETTLE_CYCLES);
		write_regs(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)));
		src_idle_pct = 0;
		snk_idle_pct = 0;
		// stall the result side while items keep coming
		hold_requests++;
		run_random(90);
		drain(0);
		run_random(90);

		drain(SETTLE_CYCLES);
		write_regs(RST_FALLBACK_THRESHOLD, RST_FALLBACK_REORDER);
		send_frame(VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, 3, 0, 0, 0);
		put_item(make_query(SPACE_APP, '1, VAL_MAX, 62'd1));
		put_item(make_query(SPACE_APP, '1, VAL_MAX, 62'd1));
		send_frame('0, 62'd1, 62'd1, 62'd1, -1, 0, 0, 0);
		repeat (6) put_item(rand_query());

		drain(10);
		if (policy.mismatches == 0) begin
			$display("ack_frequency_receiver_policy_unit regression: pass");
		end else begin
			$display("ack_frequency_receiver_policy_unit regression: fail");
		end
		$finish;
	end

endmodule
`default_nettype wire

/* files.f */
+incdir+design
design/ackf_pkg.sv
design/ackf_in_if.sv
design/ackf_out_if.sv
design/ackf_frame_parser.sv
design/ackf_ack_decider.sv
design/ack_frequency_receiver_policy_unit.sv
tb/ack_frequency_receiver_policy_unit_test.sv
